// ===== rtl/assert_macros.svh =====
// assert_macros.svh: concurrent assertion macros for the table RTL.
// Depends on nothing; taken in by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PAT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/pat_pkg.sv =====
// pat_pkg: shared constants, codes and controller/datapath interface types
// for positional_array_table. No dependencies.
`timescale 1ns / 1ps

package pat_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 6;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;

    // Request kinds
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // Result status
    localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
    localparam logic [ST_W-1:0] ST_REJECT    = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

    // How a request ends
    localparam logic [1:0] FIN_DONE      = 2'd0;
    localparam logic [1:0] FIN_REJECT    = 2'd1;
    localparam logic [1:0] FIN_NOT_FOUND = 2'd2;
    localparam logic [1:0] FIN_FOUND     = 2'd3;

    // Datapath commands
    localparam logic [3:0] CMD_NONE       = 4'd0;
    localparam logic [3:0] CMD_LOAD       = 4'd1;
    localparam logic [3:0] CMD_INS_FIRST  = 4'd2;
    localparam logic [3:0] CMD_INS_STEP   = 4'd3;
    localparam logic [3:0] CMD_INS_PUT    = 4'd4;
    localparam logic [3:0] CMD_DEL_FIRST  = 4'd5;
    localparam logic [3:0] CMD_DEL_STEP   = 4'd6;
    localparam logic [3:0] CMD_DEL_END    = 4'd7;
    localparam logic [3:0] CMD_SRCH_FIRST = 4'd8;
    localparam logic [3:0] CMD_SRCH_STEP  = 4'd9;
    localparam logic [3:0] CMD_FINISH     = 4'd10;

    typedef struct packed {
        logic [3:0] code;
        logic [1:0] kind;
    } cmd_t;

    typedef struct packed {
        logic op_ins;
        logic op_del;
        logic op_srch;
        logic ins_ok;
        logic ins_tail;
        logic ins_last;
        logic del_ok;
        logic del_tail;
        logic del_last;
        logic empty;
        logic match;
        logic srch_last;
    } flags_t;

endpackage

// ===== rtl/pat_datapath.sv =====
// pat_datapath: entry memory, count, address sequencing and result registers.
// Depends on pat_pkg; driven by pat_ctrl through pat_pkg::cmd_t.
`timescale 1ns / 1ps

module pat_datapath #(
    parameter int TABLE_DEPTH = pat_pkg::TABLE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pat_pkg::cmd_t                      cmd,
    output pat_pkg::flags_t                    flags,
    input  logic [pat_pkg::OP_W-1:0]           operation,
    input  logic signed [pat_pkg::VALUE_W-1:0] item_value,
    input  logic [pat_pkg::POS_W-1:0]          slot_position,
    output logic [pat_pkg::ST_W-1:0]           status,
    output logic [pat_pkg::POS_W-1:0]          found_position,
    output logic [pat_pkg::POS_W-1:0]          entry_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int WW = ((CW > pat_pkg::POS_W) ? CW : pat_pkg::POS_W) + 1;

    logic [pat_pkg::VALUE_W-1:0] entries_reg [TABLE_DEPTH];
    logic [pat_pkg::VALUE_W-1:0] rd_data_reg;

    logic [pat_pkg::OP_W-1:0]    op_reg;
    logic [pat_pkg::VALUE_W-1:0] value_reg;
    logic [pat_pkg::POS_W-1:0]   pos_reg;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [AW-1:0]               addr_reg, addr_next;
    logic [pat_pkg::ST_W-1:0]    status_reg, status_next;
    logic [pat_pkg::POS_W-1:0]   found_reg, found_next;
    logic [pat_pkg::POS_W-1:0]   count_out_reg, count_out_next;

    logic [WW-1:0] pos_w, cnt_w, slot_w, addr_w, found_w;
    logic [AW-1:0] slot_a;
    logic          full;

    logic                        rd_en, wr_en;
    logic [AW-1:0]               rd_addr, wr_addr;
    logic [pat_pkg::VALUE_W-1:0] wr_data;

    assign pos_w   = WW'(pos_reg);
    assign cnt_w   = WW'(cnt_reg);
    assign addr_w  = WW'(addr_reg);
    assign slot_w  = (pos_w == '0) ? '0 : pos_w - WW'(1);
    assign slot_a  = slot_w[AW-1:0];
    assign found_w = addr_w + WW'(1);
    assign full    = (cnt_w >= WW'(TABLE_DEPTH));

    always_comb
    begin
        flags.op_ins    = (op_reg == pat_pkg::OP_INSERT);
        flags.op_del    = (op_reg == pat_pkg::OP_DELETE);
        flags.op_srch   = (op_reg == pat_pkg::OP_SEARCH);
        // position 0 counts as 1 for insert
        flags.ins_ok    = !full && (slot_w <= cnt_w);
        flags.ins_tail  = (slot_w == cnt_w);
        flags.ins_last  = (AW'(addr_reg - AW'(1)) == slot_a);
        flags.del_ok    = (pos_w != '0) && (pos_w <= cnt_w);
        flags.del_tail  = (pos_w == cnt_w);
        flags.del_last  = ((addr_w + WW'(2)) == cnt_w);
        flags.empty     = (cnt_w == '0);
        flags.match     = (rd_data_reg == value_reg);
        flags.srch_last = (found_w == cnt_w);
    end

    // Memory port control and next values
    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = addr_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = rd_data_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        count_out_next = count_out_reg;
        case (cmd.code)
            pat_pkg::CMD_INS_FIRST:
            begin
                rd_en     = 1'b1;
                rd_addr   = AW'(cnt_w - WW'(1));
                addr_next = cnt_reg[AW-1:0];
            end
            pat_pkg::CMD_INS_STEP:
            begin
                // write the word read last cycle one place up, fetch the next
                wr_en     = 1'b1;
                rd_en     = !flags.ins_last;
                rd_addr   = AW'(addr_reg - AW'(2));
                addr_next = AW'(addr_reg - AW'(1));
            end
            pat_pkg::CMD_INS_PUT:
            begin
                wr_en    = 1'b1;
                wr_addr  = slot_a;
                wr_data  = value_reg;
                cnt_next = CW'(cnt_reg + CW'(1));
            end
            pat_pkg::CMD_DEL_FIRST:
            begin
                rd_en     = 1'b1;
                rd_addr   = AW'(slot_w + WW'(1));
                addr_next = slot_a;
            end
            pat_pkg::CMD_DEL_STEP:
            begin
                wr_en     = 1'b1;
                rd_en     = !flags.del_last;
                rd_addr   = AW'(addr_reg + AW'(2));
                addr_next = AW'(addr_reg + AW'(1));
            end
            pat_pkg::CMD_DEL_END:
            begin
                cnt_next = CW'(cnt_reg - CW'(1));
            end
            pat_pkg::CMD_SRCH_FIRST:
            begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                addr_next = '0;
            end
            pat_pkg::CMD_SRCH_STEP:
            begin
                // hold the address on a hit so the finish sees it
                rd_en   = !flags.match && !flags.srch_last;
                rd_addr = AW'(addr_reg + AW'(1));
                if (!flags.match && !flags.srch_last)
                begin
                    addr_next = AW'(addr_reg + AW'(1));
                end
            end
            pat_pkg::CMD_FINISH:
            begin
                count_out_next = cnt_w[pat_pkg::POS_W-1:0];
                found_next     = '0;
                case (cmd.kind)
                    pat_pkg::FIN_REJECT:    status_next = pat_pkg::ST_REJECT;
                    pat_pkg::FIN_NOT_FOUND: status_next = pat_pkg::ST_NOT_FOUND;
                    pat_pkg::FIN_FOUND:
                    begin
                        status_next = pat_pkg::ST_DONE;
                        found_next  = found_w[pat_pkg::POS_W-1:0];
                    end
                    default:                status_next = pat_pkg::ST_DONE;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entries_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.code == pat_pkg::CMD_LOAD)
        begin
            op_reg    <= operation;
            value_reg <= $unsigned(item_value);
            pos_reg   <= slot_position;
        end
        addr_reg      <= addr_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        count_out_reg <= count_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign status         = status_reg;
    assign found_position = found_reg;
    assign entry_count    = count_out_reg;

endmodule

// ===== rtl/pat_ctrl.sv =====
// pat_ctrl: request sequencer and channel handshake for the table.
// Depends on pat_pkg; commands pat_datapath through pat_pkg::cmd_t.
`timescale 1ns / 1ps

module pat_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  pat_pkg::flags_t flags,
    output pat_pkg::cmd_t   cmd
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DECODE     = 4'd1;
    localparam logic [3:0] S_INS_FIRST  = 4'd2;
    localparam logic [3:0] S_INS_STEP   = 4'd3;
    localparam logic [3:0] S_INS_PUT    = 4'd4;
    localparam logic [3:0] S_DEL_FIRST  = 4'd5;
    localparam logic [3:0] S_DEL_STEP   = 4'd6;
    localparam logic [3:0] S_DEL_END    = 4'd7;
    localparam logic [3:0] S_SRCH_FIRST = 4'd8;
    localparam logic [3:0] S_SRCH_STEP  = 4'd9;
    localparam logic [3:0] S_FINISH     = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd.code   = pat_pkg::CMD_NONE;
        cmd.kind   = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.code   = pat_pkg::CMD_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                kind_next  = pat_pkg::FIN_REJECT;
                if (flags.op_ins && flags.ins_ok)
                begin
                    state_next = flags.ins_tail ? S_INS_PUT : S_INS_FIRST;
                end
                else if (flags.op_del && flags.del_ok)
                begin
                    state_next = flags.del_tail ? S_DEL_END : S_DEL_FIRST;
                end
                else if (flags.op_srch)
                begin
                    if (flags.empty)
                    begin
                        kind_next = pat_pkg::FIN_NOT_FOUND;
                    end
                    else
                    begin
                        state_next = S_SRCH_FIRST;
                    end
                end
            end
            S_INS_FIRST:
            begin
                cmd.code   = pat_pkg::CMD_INS_FIRST;
                state_next = S_INS_STEP;
            end
            S_INS_STEP:
            begin
                cmd.code = pat_pkg::CMD_INS_STEP;
                if (flags.ins_last)
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                cmd.code   = pat_pkg::CMD_INS_PUT;
                kind_next  = pat_pkg::FIN_DONE;
                state_next = S_FINISH;
            end
            S_DEL_FIRST:
            begin
                cmd.code   = pat_pkg::CMD_DEL_FIRST;
                state_next = S_DEL_STEP;
            end
            S_DEL_STEP:
            begin
                cmd.code = pat_pkg::CMD_DEL_STEP;
                if (flags.del_last)
                begin
                    state_next = S_DEL_END;
                end
            end
            S_DEL_END:
            begin
                cmd.code   = pat_pkg::CMD_DEL_END;
                kind_next  = pat_pkg::FIN_DONE;
                state_next = S_FINISH;
            end
            S_SRCH_FIRST:
            begin
                cmd.code   = pat_pkg::CMD_SRCH_FIRST;
                state_next = S_SRCH_STEP;
            end
            S_SRCH_STEP:
            begin
                cmd.code = pat_pkg::CMD_SRCH_STEP;
                if (flags.match)
                begin
                    kind_next  = pat_pkg::FIN_FOUND;
                    state_next = S_FINISH;
                end
                else if (flags.srch_last)
                begin
                    kind_next  = pat_pkg::FIN_NOT_FOUND;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // wait here until the output register can take the result
                if (slot_free)
                begin
                    cmd.code   = pat_pkg::CMD_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.code == pat_pkg::CMD_FINISH)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= pat_pkg::FIN_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/positional_array_table.sv =====
// positional_array_table: top level; joins pat_ctrl and pat_datapath.
// Depends on pat_pkg, pat_ctrl, pat_datapath and assert_macros.svh.
`timescale 1ns / 1ps

// Dense ordered table of TABLE_DEPTH signed 32-bit words with a live count.
// Each input item is an insert (operation 0: place item_value at 1-based
// slot_position, 0 taken as 1, later entries move up), a delete (1: remove
// the entry at slot_position, later entries move down) or a search (2: first
// 1-based position holding item_value). Every item gives exactly one result:
// status (0 done, 1 rejected, 2 not found), found_position (nonzero only on
// a hit) and entry_count after the item. Inserts into a full table or past
// count+1, deletes at 0 or past the count, and operation code 3 are rejected
// and change nothing. Items run one at a time. Entries live in a memory with
// one write and one registered read per cycle, so inserts and deletes move the
// later entries one at a time and a search compares the entries in order from
// the first. The input is taken again once the result is in the output
// register, even while that result is still stalled; a finished item then
// waits for the register to free up. Reset clears the sequencer and the count
// but not the memory: no memory clearing pass is needed.

`include "assert_macros.svh"

module positional_array_table #(
    parameter int TABLE_DEPTH = pat_pkg::TABLE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pat_pkg::OP_W-1:0]           operation,
    input  logic signed [pat_pkg::VALUE_W-1:0] item_value,
    input  logic [pat_pkg::POS_W-1:0]          slot_position,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [pat_pkg::ST_W-1:0]           status,
    output logic [pat_pkg::POS_W-1:0]          found_position,
    output logic [pat_pkg::POS_W-1:0]          entry_count
);

    pat_pkg::cmd_t   cmd;
    pat_pkg::flags_t flags;

    // Sequencer: decodes the item and steps the datapath through it
    pat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .flags     (flags),
        .cmd       (cmd)
    );

    // Memory, count, address walk and result registers
    pat_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .flags          (flags),
        .operation      (operation),
        .item_value     (item_value),
        .slot_position  (slot_position),
        .status         (status),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

    // An accepted item holds the input off for at least the next cycle
    `PAT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall)
    // A reported position only comes with a successful search
    `PAT_ASSERT_IMPL(a_found_done, clk, rst_n, out_valid && (found_position != '0),
        status == pat_pkg::ST_DONE)
    // While out_valid is high, status is one of the three defined codes
    `PAT_ASSERT_IMPL(a_status_legal, clk, rst_n, out_valid,
        (status == pat_pkg::ST_DONE) || (status == pat_pkg::ST_REJECT) || (status == pat_pkg::ST_NOT_FOUND))
    // The count never passes the table depth
    `PAT_ASSERT_IMPL(a_count_bound, clk, rst_n, out_valid,
        (TABLE_DEPTH > 63) || (int'(entry_count) <= TABLE_DEPTH))

endmodule
